### sv/stcodec_pkg.sv
// package: shared types and constants of the six-bit text codec
`default_nettype none

package stcodec_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_DIRECTION = 2'd0;

   // direction register values
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // character set: six-bit value plus a fixed offset
   localparam logic [7:0] CHAR_BASE  = 8'h3c;
   localparam logic [7:0] CHAR_LIMIT = 8'h80;

   // bit positions within a message
   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;
   localparam logic [1:0] PHASE_3 = 2'd3;

   // one result of the codec
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_data;
      logic       end_of_message;
      logic       bad_char;
   } result_type;

   localparam result_type RESULT_NONE = '{out_byte: 8'h00, has_data: 1'b0,
                                          end_of_message: 1'b0, bad_char: 1'b0};

endpackage

`default_nettype wire

### sv/six_bit_text_codec.sv
// top level: streaming codec between bytes and six-bit printable characters
`default_nettype none

// Encodes bytes into characters (six-bit value plus 0x3c) or decodes such characters back
// into bytes, as the direction register selects. A transaction enters an input register,
// one pass of logic turns it into zero, one or two results, and those go into a two-slot
// result register that drains one result per cycle while rsp_stall is low. A new
// transaction is taken every cycle as long as each yields at most one result and the
// result channel does not stall; a transaction that yields two results (every third
// byte when encoding, or a last byte with leftover bits) holds the result register until
// both have drained. Transactions that yield nothing (first character of a decode group,
// characters after an error) pass without touching the result register. Write direction
// only while idle; a write abandons any message in progress.
module six_bit_text_codec (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input channel
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic [7:0]                           req_in_byte,
   input  wire logic                                 req_is_last,
   // result channel
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic [7:0]                           rsp_out_byte,
   output      logic                                 rsp_has_data,
   output      logic                                 rsp_end_of_message,
   output      logic                                 rsp_bad_char,
   // configuration port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [stcodec_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [stcodec_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [stcodec_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                                 csr_pready
);

   // registers
   logic                     direction_ff, direction_in;
   logic [1:0]               phase_ff, phase_in;
   logic [7:0]               carry_ff, carry_in;
   logic                     error_ff, error_in;
   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     in_last_ff;
   logic [1:0]               grp_cnt_ff, grp_cnt_in;
   logic                     grp_idx_ff, grp_idx_in;
   stcodec_pkg::result_type  slot0_ff, slot1_ff;

   // combinational results of the single pass
   stcodec_pkg::result_type  slot0_n, slot1_n;
   logic [1:0]               cnt_n;
   logic [1:0]               phase_n;
   logic [7:0]               carry_n;
   logic                     error_n;

   logic cfg_write;
   logic req_fire;
   logic rsp_fire;
   logic last_slot;
   logic grp_free;
   logic proc;

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == stcodec_pkg::CSR_ADDR_DIRECTION);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == stcodec_pkg::CSR_ADDR_DIRECTION) begin
         csr_prdata[0] = direction_ff;
      end
   end

   // handshakes
   assign rsp_valid = (grp_cnt_ff != 2'd0);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign last_slot = (grp_cnt_ff != 2'd2) || grp_idx_ff;
   assign grp_free  = (grp_cnt_ff == 2'd0) || (rsp_fire && last_slot);
   assign proc      = in_valid_ff && ((cnt_n == 2'd0) || grp_free);
   assign req_stall = in_valid_ff && !proc;
   assign req_fire  = req_valid && !req_stall;

   // encode or decode the held transaction
   always_comb begin
      logic [1:0] p_enc;
      logic [7:0] made;
      logic [5:0] rest;
      logic [7:0] ch_full;
      logic [5:0] ch;
      logic       bad;

      p_enc   = (phase_ff == stcodec_pkg::PHASE_3) ? stcodec_pkg::PHASE_0 : phase_ff;
      made    = carry_ff;
      rest    = 6'd0;
      ch_full = in_byte_ff - stcodec_pkg::CHAR_BASE;
      ch      = ch_full[5:0];
      bad     = (in_byte_ff < stcodec_pkg::CHAR_BASE) || (in_byte_ff >= stcodec_pkg::CHAR_LIMIT);

      slot0_n = stcodec_pkg::RESULT_NONE;
      slot1_n = stcodec_pkg::RESULT_NONE;
      cnt_n   = 2'd0;
      phase_n = phase_ff;
      carry_n = carry_ff;
      error_n = error_ff;

      if (direction_ff == stcodec_pkg::DIR_ENCODE) begin
         // split the byte at the current bit position
         case (p_enc)
            stcodec_pkg::PHASE_0: begin
               made = carry_ff | {2'b00, in_byte_ff[7:2]};
               rest = {in_byte_ff[1:0], 4'b0000};
            end
            stcodec_pkg::PHASE_1: begin
               made = carry_ff | {4'b0000, in_byte_ff[7:4]};
               rest = {in_byte_ff[3:0], 2'b00};
            end
            default: begin
               made = carry_ff | {6'b000000, in_byte_ff[7:6]};
               rest = in_byte_ff[5:0];
            end
         endcase
         slot0_n.out_byte = {2'b00, made[5:0]} + stcodec_pkg::CHAR_BASE;
         slot0_n.has_data = 1'b1;
         slot1_n.out_byte = {2'b00, rest} + stcodec_pkg::CHAR_BASE;
         slot1_n.has_data = 1'b1;
         // third byte, or leftover flush at message end
         if ((p_enc == stcodec_pkg::PHASE_2) || in_last_ff) begin
            cnt_n = 2'd2;
         end else begin
            cnt_n = 2'd1;
         end
         if (p_enc == stcodec_pkg::PHASE_2) begin
            phase_n = stcodec_pkg::PHASE_0;
            carry_n = 8'h00;
         end else begin
            phase_n = p_enc + 2'd1;
            carry_n = {2'b00, rest};
         end
      end else if (!error_ff) begin
         if (bad) begin
            // error result, rest of the message is suppressed
            error_n          = 1'b1;
            slot0_n.bad_char = 1'b1;
            cnt_n            = 2'd1;
         end else begin
            // gather six bits per character into bytes
            slot0_n.has_data = 1'b1;
            case (phase_ff)
               stcodec_pkg::PHASE_0: begin
                  carry_n = {ch, 2'b00};
                  phase_n = stcodec_pkg::PHASE_1;
               end
               stcodec_pkg::PHASE_1: begin
                  slot0_n.out_byte = carry_ff | {6'b000000, ch[5:4]};
                  cnt_n            = 2'd1;
                  carry_n          = {ch[3:0], 4'b0000};
                  phase_n          = stcodec_pkg::PHASE_2;
               end
               stcodec_pkg::PHASE_2: begin
                  slot0_n.out_byte = carry_ff | {4'b0000, ch[5:2]};
                  cnt_n            = 2'd1;
                  carry_n          = {ch[1:0], 6'b000000};
                  phase_n          = stcodec_pkg::PHASE_3;
               end
               default: begin
                  slot0_n.out_byte = carry_ff | {2'b00, ch};
                  cnt_n            = 2'd1;
                  carry_n          = 8'h00;
                  phase_n          = stcodec_pkg::PHASE_0;
               end
            endcase
         end
      end

      // message end: mark the final result, add a bare marker if none
      if (in_last_ff) begin
         if (cnt_n == 2'd0) begin
            slot0_n          = stcodec_pkg::RESULT_NONE;
            slot0_n.bad_char = error_n;
            cnt_n            = 2'd1;
         end
         if (cnt_n == 2'd2) begin
            slot1_n.end_of_message = 1'b1;
         end else begin
            slot0_n.end_of_message = 1'b1;
         end
         phase_n = stcodec_pkg::PHASE_0;
         carry_n = 8'h00;
         error_n = 1'b0;
      end
   end

   // next values of message state and direction
   always_comb begin
      direction_in = direction_ff;
      phase_in     = phase_ff;
      carry_in     = carry_ff;
      error_in     = error_ff;
      if (cfg_write) begin
         direction_in = csr_pwdata[0];
         phase_in     = stcodec_pkg::PHASE_0;
         carry_in     = 8'h00;
         error_in     = 1'b0;
      end else if (proc) begin
         phase_in = phase_n;
         carry_in = carry_n;
         error_in = error_n;
      end
   end

   // next values of input register and result group control
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end

      grp_cnt_in = grp_cnt_ff;
      grp_idx_in = grp_idx_ff;
      if (proc && (cnt_n != 2'd0)) begin
         grp_cnt_in = cnt_n;
         grp_idx_in = 1'b0;
      end else if (rsp_fire) begin
         if (last_slot) begin
            grp_cnt_in = 2'd0;
            grp_idx_in = 1'b0;
         end else begin
            grp_idx_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= stcodec_pkg::DIR_ENCODE;
         phase_ff     <= stcodec_pkg::PHASE_0;
         carry_ff     <= 8'h00;
         error_ff     <= 1'b0;
         in_valid_ff  <= 1'b0;
         grp_cnt_ff   <= 2'd0;
         grp_idx_ff   <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         phase_ff     <= phase_in;
         carry_ff     <= carry_in;
         error_ff     <= error_in;
         in_valid_ff  <= in_valid_in;
         grp_cnt_ff   <= grp_cnt_in;
         grp_idx_ff   <= grp_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_is_last;
      end
      if (proc && (cnt_n != 2'd0)) begin
         slot0_ff <= slot0_n;
         slot1_ff <= slot1_n;
      end
   end

   // result output
   always_comb begin
      stcodec_pkg::result_type cur;
      cur                = grp_idx_ff ? slot1_ff : slot0_ff;
      rsp_out_byte       = cur.out_byte;
      rsp_has_data       = cur.has_data;
      rsp_end_of_message = cur.end_of_message;
      rsp_bad_char       = cur.bad_char;
   end

endmodule

`default_nettype wire

### sv/stcodec_checker.sv
// checker: port-level properties of the six-bit text codec, bound to the top level
`default_nettype none

module stcodec_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic [7:0]                           rsp_out_byte,
   input wire logic                                 rsp_has_data,
   input wire logic                                 rsp_end_of_message,
   input wire logic                                 rsp_bad_char
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_has_data)
      && $stable(rsp_end_of_message) && $stable(rsp_bad_char))
      else $error("result changed while stalled");

   // a result without data carries a zero byte
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_out_byte == 8'h00)
      else $error("nonzero byte on a result without data");

   // a bare result is either an end marker or an error marker
   a_bare_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_data |-> rsp_end_of_message || rsp_bad_char)
      else $error("bare result with neither end nor error flag");

   // an error result never carries data
   a_bad_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_char |-> !rsp_has_data)
      else $error("error result carries data");

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind six_bit_text_codec stcodec_checker u_stcodec_checker (.*);

`default_nettype wire
